// ===== rtl/core/rtmpd_pkg.sv =====
// shared types, constants and helpers of the rtmp chunk stream deframer
`timescale 1ns / 1ps
package rtmpd_pkg;

  // default number of chunk stream slots
  localparam int unsigned ChannelSlotsDefault = 8;

  // register reset values and special codes
  localparam logic [23:0] ChunkSizeReset = 24'd128;
  localparam logic [23:0] MaxMsgLenReset = 24'(10 << 20);
  localparam logic [23:0] ExtStampMark   = 24'hFFFFFF;
  localparam int unsigned ModSteps       = 24;

  // register map index
  localparam logic RegChunkSize = 1'b0;
  localparam logic RegMaxMsgLen = 1'b1;

  // fault codes
  typedef enum logic [1:0] {
    ErrUnknownChannel = 2'd0,
    ErrTableFull      = 2'd1,
    ErrOversize       = 2'd2
  } err_code_e;

  // parse position within the chunk stream
  typedef enum logic [5:0] {
    PhInit    = 6'b000001,
    PhBasic   = 6'b000010,
    PhMsgHdr  = 6'b000100,
    PhExt     = 6'b001000,
    PhPayload = 6'b010000,
    PhHalt    = 6'b100000
  } phase_e;

  // controller sequence states
  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SStep   = 6'b000010,
    SSettle = 6'b000100,
    SLookup = 6'b001000,
    SFinish = 6'b010000,
    SMod    = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        message_end;
    logic [16:0] chunk_stream_id;
    logic [7:0]  message_type;
    logic [31:0] message_clock;
    logic        error_flag;
    logic [1:0]  error_code;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_byte;
    logic hdr_byte;
    logic pay_byte;
    logic lookup;
    logic finish;
    logic mod_start;
    logic mod_iter;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_payload;
    logic halted;
    logic rem_valid;
    logic need_lookup;
    logic need_finish;
    logic mod_last;
    logic out_free;
  } dp_status_t;

  // message header length by fmt
  function automatic logic [3:0] hdr_bytes(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      2'd0: n = 4'd11;
      2'd1: n = 4'd7;
      2'd2: n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/rtmpd_chan_if.sv =====
// valid/ready channel carrying one item
`timescale 1ns / 1ps
interface rtmpd_chan_if #(
  parameter type item_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/rtmpd_ctrl.sv =====
// sequencing controller of the deframer
`timescale 1ns / 1ps
module rtmpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rtmpd_pkg::dp_status_t status_i,
  output rtmpd_pkg::dp_cmd_t    cmd_o
);
  import rtmpd_pkg::*;

  ctrl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d         = SStep;
        end
      end
      SStep: begin
        if (status_i.halted) begin
          state_d = SIdle;
        end else if (status_i.in_payload) begin
          if (!status_i.rem_valid) begin
            cmd_o.mod_start = 1'b1;
            state_d         = SMod;
          end else if (status_i.out_free) begin
            cmd_o.pay_byte = 1'b1;
            state_d        = SIdle;
          end
        end else begin
          cmd_o.hdr_byte = 1'b1;
          state_d        = SSettle;
        end
      end
      SSettle: begin
        if (status_i.need_lookup) begin
          state_d = SLookup;
        end else if (status_i.need_finish) begin
          state_d = SFinish;
        end else begin
          state_d = SIdle;
        end
      end
      SLookup: begin
        if (status_i.out_free) begin
          cmd_o.lookup = 1'b1;
          state_d      = SSettle;
        end
      end
      SFinish: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = SIdle;
        end
      end
      SMod: begin
        cmd_o.mod_iter = 1'b1;
        if (status_i.mod_last) begin
          state_d = SStep;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/core/rtmpd_dpath.sv =====
// header parser, slot table, chunk position and output register
`timescale 1ns / 1ps
module rtmpd_dpath #(
  parameter int unsigned ChannelSlots = rtmpd_pkg::ChannelSlotsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rtmpd_pkg::dp_cmd_t    cmd_i,
  output rtmpd_pkg::dp_status_t status_o,
  input  logic [7:0]            in_byte_i,
  input  logic [23:0]           chunk_size_i,
  input  logic [23:0]           max_len_i,
  input  logic                  chunk_size_wr_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rtmpd_pkg::out_item_t  out_item_o
);
  import rtmpd_pkg::*;

  localparam int unsigned SlotW = (ChannelSlots > 1) ? $clog2(ChannelSlots) : 1;

  // parse registers
  logic [7:0]  byte_q;
  phase_e      phase_q, phase_d;
  logic [4:0]  hc_q, hc_d;
  logic [1:0]  bl_q, bl_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [16:0] cid_q, cid_d;
  logic [7:0]  hbuf_q [11];
  logic [7:0]  hbuf_d [11];
  logic [31:0] fa_q, fa_d;
  logic [SlotW-1:0] slot_q, slot_d;

  // slot table
  logic        used_q  [ChannelSlots];
  logic        used_d  [ChannelSlots];
  logic [16:0] chan_q  [ChannelSlots];
  logic [16:0] chan_d  [ChannelSlots];
  logic [23:0] stamp_q [ChannelSlots];
  logic [23:0] stamp_d [ChannelSlots];
  logic [23:0] len_q   [ChannelSlots];
  logic [23:0] len_d   [ChannelSlots];
  logic [7:0]  type_q  [ChannelSlots];
  logic [7:0]  type_d  [ChannelSlots];
  logic [31:0] clock_q [ChannelSlots];
  logic [31:0] clock_d [ChannelSlots];
  logic [23:0] recv_q  [ChannelSlots];
  logic [23:0] recv_d  [ChannelSlots];

  // chunk position and its remainder unit
  logic [24:0] rem_q, rem_d;
  logic        rem_valid_q, rem_valid_d;
  logic [4:0]  mod_cnt_q, mod_cnt_d;
  logic [23:0] mod_src_q, mod_src_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // derived values
  logic [24:0] eff;
  logic [4:0]  hdr_len, ext_len;
  logic        ext;
  logic        out_free;
  logic [5:0]  low;
  logic [1:0]  bl_new;
  logic [4:0]  k;
  logic [SlotW-1:0] hit_idx, free_idx;
  logic        hit, free_found;
  logic [23:0] cur_stamp, cur_len, cur_recv;
  logic [31:0] cur_clock, ts, new_clk;
  logic [23:0] r1;
  logic [24:0] rem_inc, rem_next, mod_t;

  assign eff       = (chunk_size_i == 24'd0) ? 25'h1000000 : {1'b0, chunk_size_i};
  assign cur_stamp = stamp_q[slot_q];
  assign cur_len   = len_q[slot_q];
  assign cur_recv  = recv_q[slot_q];
  assign cur_clock = clock_q[slot_q];
  assign ext       = (cur_stamp == ExtStampMark);
  assign hdr_len   = {3'b0, bl_q} + {1'b0, hdr_bytes(fmt_q)};
  assign ext_len   = hdr_len + (ext ? 5'd4 : 5'd0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign low       = byte_q[5:0];
  assign bl_new    = (low == 6'd0) ? 2'd2 : ((low == 6'd1) ? 2'd3 : 2'd1);
  assign k         = hc_q - {3'b0, bl_q};
  assign ts        = ext ? fa_q : {8'b0, cur_stamp};
  assign new_clk   = (cur_recv != 24'd0) ? cur_clock :
                     ((fmt_q == 2'd0) ? ts : cur_clock + ts);
  assign r1        = cur_recv + 24'd1;
  assign rem_inc   = rem_q + 25'd1;
  assign rem_next  = (rem_inc == eff) ? 25'd0 : rem_inc;
  assign mod_t     = {rem_q[23:0], mod_src_q[23]};

  // slot search, lowest index wins
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = ChannelSlots - 1; i >= 0; i--) begin
      if (used_q[i] && chan_q[i] == cid_q) begin
        hit     = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  // status
  always_comb begin
    status_o             = '0;
    status_o.in_payload  = (phase_q == PhPayload);
    status_o.halted      = (phase_q == PhHalt);
    status_o.rem_valid   = rem_valid_q;
    status_o.need_lookup = (phase_q == PhMsgHdr) && (hc_q >= hdr_len);
    status_o.need_finish = (phase_q == PhExt) && (hc_q >= ext_len);
    status_o.mod_last    = (mod_cnt_q == 5'd1);
    status_o.out_free    = out_free;
  end

  // next state of parser, table and output
  always_comb begin
    phase_d     = phase_q;
    hc_d        = hc_q;
    bl_d        = bl_q;
    fmt_d       = fmt_q;
    cid_d       = cid_q;
    hbuf_d      = hbuf_q;
    fa_d        = fa_q;
    slot_d      = slot_q;
    used_d      = used_q;
    chan_d      = chan_q;
    stamp_d     = stamp_q;
    len_d       = len_q;
    type_d      = type_q;
    clock_d     = clock_q;
    recv_d      = recv_q;
    rem_d       = rem_q;
    rem_valid_d = rem_valid_q && !chunk_size_wr_i;
    mod_cnt_d   = mod_cnt_q;
    mod_src_d   = mod_src_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    // header byte
    if (cmd_i.hdr_byte) begin
      case (phase_q)
        PhInit: begin
          fmt_d   = byte_q[7:6];
          bl_d    = bl_new;
          cid_d   = (bl_new == 2'd1) ? {11'b0, low} : 17'd64;
          hc_d    = 5'd1;
          phase_d = (bl_new == 2'd1) ? PhMsgHdr : PhBasic;
        end
        PhBasic: begin
          if (hc_q == 5'd1) begin
            cid_d = cid_q + {9'b0, byte_q};
          end else begin
            cid_d = cid_q + {1'b0, byte_q, 8'b0};
          end
          hc_d = hc_q + 5'd1;
          if (hc_q + 5'd1 >= {3'b0, bl_q}) begin
            phase_d = PhMsgHdr;
          end
        end
        PhMsgHdr: begin
          if (k < 5'd11) begin
            hbuf_d[k[3:0]] = byte_q;
          end
          hc_d = hc_q + 5'd1;
        end
        PhExt: begin
          fa_d = {fa_q[23:0], byte_q};
          hc_d = hc_q + 5'd1;
        end
        default: ;
      endcase
    end

    // slot lookup at header end
    if (cmd_i.lookup) begin
      if (!hit && fmt_q >= 2'd2) begin
        phase_d     = PhHalt;
        out_valid_d = 1'b1;
        out_d       = '0;
        out_d.chunk_stream_id = cid_q;
        out_d.error_flag      = 1'b1;
        out_d.error_code      = ErrUnknownChannel;
      end else if (!hit && !free_found) begin
        phase_d     = PhHalt;
        out_valid_d = 1'b1;
        out_d       = '0;
        out_d.chunk_stream_id = cid_q;
        out_d.error_flag      = 1'b1;
        out_d.error_code      = ErrTableFull;
      end else begin
        if (hit) begin
          slot_d = hit_idx;
        end else begin
          slot_d             = free_idx;
          used_d[free_idx]   = 1'b1;
          chan_d[free_idx]   = cid_q;
          stamp_d[free_idx]  = '0;
          len_d[free_idx]    = '0;
          type_d[free_idx]   = '0;
          clock_d[free_idx]  = '0;
          recv_d[free_idx]   = '0;
        end
        if (fmt_q <= 2'd2) begin
          stamp_d[slot_d] = {hbuf_q[0], hbuf_q[1], hbuf_q[2]};
        end
        if (fmt_q <= 2'd1) begin
          len_d[slot_d]  = {hbuf_q[3], hbuf_q[4], hbuf_q[5]};
          type_d[slot_d] = hbuf_q[6];
        end
        fa_d    = '0;
        phase_d = PhExt;
      end
    end

    // clock update and message start checks
    if (cmd_i.finish) begin
      clock_d[slot_q] = new_clk;
      rem_valid_d     = 1'b0;
      if (cur_recv == 24'd0 && cur_len > max_len_i) begin
        phase_d     = PhHalt;
        out_valid_d = 1'b1;
        out_d       = '0;
        out_d.chunk_stream_id = cid_q;
        out_d.error_flag      = 1'b1;
        out_d.error_code      = ErrOversize;
      end else if (cur_recv >= cur_len) begin
        recv_d[slot_q] = '0;
        phase_d        = PhInit;
        out_valid_d    = 1'b1;
        out_d          = '0;
        out_d.message_end     = 1'b1;
        out_d.chunk_stream_id = cid_q;
        out_d.message_type    = type_q[slot_q];
        out_d.message_clock   = new_clk;
      end else begin
        phase_d = PhPayload;
      end
    end

    // payload byte
    if (cmd_i.pay_byte) begin
      rem_d       = rem_next;
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.payload_byte    = byte_q;
      out_d.byte_valid      = 1'b1;
      out_d.chunk_stream_id = cid_q;
      out_d.message_type    = type_q[slot_q];
      out_d.message_clock   = cur_clock;
      if (r1 >= cur_len) begin
        out_d.message_end = 1'b1;
        recv_d[slot_q]    = '0;
        phase_d           = PhInit;
      end else begin
        recv_d[slot_q] = r1;
        if (rem_next == 25'd0) begin
          phase_d = PhInit;
        end
      end
    end

    // received count modulo chunk size, one bit a cycle
    if (cmd_i.mod_start) begin
      mod_src_d = cur_recv;
      rem_d     = '0;
      mod_cnt_d = 5'(ModSteps);
    end
    if (cmd_i.mod_iter) begin
      rem_d     = (mod_t >= eff) ? mod_t - eff : mod_t;
      mod_src_d = {mod_src_q[22:0], 1'b0};
      mod_cnt_d = mod_cnt_q - 5'd1;
      if (mod_cnt_q == 5'd1) begin
        rem_valid_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhInit;
      hc_q        <= '0;
      bl_q        <= '0;
      fmt_q       <= '0;
      slot_q      <= '0;
      rem_valid_q <= 1'b0;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ChannelSlots; i++) begin
        used_q[i] <= 1'b0;
      end
    end else begin
      phase_q     <= phase_d;
      hc_q        <= hc_d;
      bl_q        <= bl_d;
      fmt_q       <= fmt_d;
      slot_q      <= slot_d;
      rem_valid_q <= rem_valid_d;
      mod_cnt_q   <= mod_cnt_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_byte_i;
    end
    cid_q     <= cid_d;
    hbuf_q    <= hbuf_d;
    fa_q      <= fa_d;
    chan_q    <= chan_d;
    stamp_q   <= stamp_d;
    len_q     <= len_d;
    type_q    <= type_d;
    clock_q   <= clock_d;
    recv_q    <= recv_d;
    rem_q     <= rem_d;
    mod_src_q <= mod_src_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

// ===== rtl/core/rtmp_chunk_stream_deframer.sv =====
// top level of the rtmp chunk stream deframer
// Usage:
//   in_i carries one raw chunk stream byte per item; out_o carries one result
//   item per payload byte, one per zero-length message and one per fault.
//   Items move when valid and ready are both high at a rising clock edge.
//   The apb port sets chunk_size (address 0) and max_message_length
//   (address 4); write them only while the block is idle.
// Sequence:
//   a payload byte passes the idle and step states; a header byte passes
//   idle, step and settle, and the byte that completes a header then runs
//   the slot search, a second settle check and the clock update. The first
//   payload byte after a header, or after a chunk_size write, first runs a
//   shift-subtract remainder of the received count.
//   The slot search compares all CHANNEL_SLOTS entries combinationally.
// Reset: the table is emptied and both registers return to 128 and 10 MiB.
// Stall: a result waits in the output register while the next byte is
//   accepted; work that produces a result holds until that register frees.
// A fault emits one error result and all later bytes are dropped until reset.
`timescale 1ns / 1ps
module rtmp_chunk_stream_deframer #(
  parameter int unsigned CHANNEL_SLOTS = rtmpd_pkg::ChannelSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtmpd_chan_if.sink   in_i,
  rtmpd_chan_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtmpd_pkg::*;

  logic [23:0] chunk_size_q;
  logic [23:0] max_len_q;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_status_t  status;
  in_item_t    in_item;
  out_item_t   out_item;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxMsgLen) ? {8'b0, max_len_q} : {8'b0, chunk_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= ChunkSizeReset;
      max_len_q    <= MaxMsgLenReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegChunkSize) begin
        chunk_size_q <= pwdata[23:0];
      end else begin
        max_len_q <= pwdata[23:0];
      end
    end
  end

  assign in_item    = in_i.item;
  assign out_o.item = out_item;

  // controller
  rtmpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  rtmpd_dpath #(
    .ChannelSlots (CHANNEL_SLOTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_byte_i       (in_item.stream_byte),
    .chunk_size_i    (chunk_size_q),
    .max_len_i       (max_len_q),
    .chunk_size_wr_i (cfg_wr && (paddr[2] == RegChunkSize)),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_item_o      (out_item)
  );
endmodule
